// File: sv/mcog_pkg.sv
// Package: shared constants, codes and the job record for the circle outline generator.
`timescale 1ns / 1ps

package mcog_pkg;

    localparam int COORD_BITS     = 10;
    localparam int RADIUS_BITS    = 9;
    localparam int COLOR_BITS     = 16;
    localparam int SIZE_BITS      = 11;
    localparam int DEC_BITS       = COORD_BITS + 3;
    localparam int SUM_BITS       = COORD_BITS + 2;
    localparam int CMP_BITS       = (SUM_BITS > SIZE_BITS) ? SUM_BITS : SIZE_BITS;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_INDEX_BITS = 1;
    localparam int SEL_BITS       = 3;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(320);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(240);

    // last pixel index within an axis job and within an octant job
    localparam logic [SEL_BITS-1:0] AXES_LAST     = SEL_BITS'(3);
    localparam logic [SEL_BITS-1:0] OCTANTS_LAST  = SEL_BITS'(7);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SCR_COLS = 1'b0,
        CFG_SCR_ROWS = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_EMPTY,
        JOB_AXES,
        JOB_OCTANTS
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [COLOR_BITS-1:0]  color;
        logic                   done;
    } job_t;

endpackage

// File: sv/mcog_front.sv
// Front end: takes commands, runs the midpoint decision update and issues pixel jobs.
`timescale 1ns / 1ps

module mcog_front
    import mcog_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    cmd,
    input  logic [COORD_BITS-1:0]   center_x,
    input  logic [COORD_BITS-1:0]   center_y,
    input  logic [RADIUS_BITS-1:0]  radius,
    input  logic [COLOR_BITS-1:0]   pen_color,
    output logic                    job_valid,
    output job_t                    job,
    input  logic                    job_ready
);

    logic [COORD_BITS-1:0] ctr_x_reg, ctr_x_next;
    logic [COORD_BITS-1:0] ctr_y_reg, ctr_y_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic [COORD_BITS-1:0] step_x_reg, step_x_next;
    logic [COORD_BITS-1:0] step_y_reg, step_y_next;
    logic [DEC_BITS-1:0]   dec_reg, dec_next;
    logic [DEC_BITS-1:0]   dx_reg, dx_next;
    logic [DEC_BITS-1:0]   dy_reg, dy_next;
    logic                  running_reg, running_next;

    logic                  accept;
    logic [COORD_BITS-1:0] radius_ext;
    logic [COORD_BITS-1:0] x_adv;
    logic [COORD_BITS-1:0] y_adv;
    logic [DEC_BITS-1:0]   dy_adv;
    logic [DEC_BITS-1:0]   dec_mid;
    logic [DEC_BITS-1:0]   dx_adv;

    assign in_ready   = job_ready;
    assign job_valid  = in_valid;
    assign accept     = in_valid && job_ready;
    assign radius_ext = COORD_BITS'(radius);

    // one midpoint iteration; decision sign is the top bit
    always_comb
    begin
        if (!dec_reg[DEC_BITS-1])
        begin
            y_adv  = step_y_reg - COORD_BITS'(1);
            dy_adv = dy_reg + DEC_BITS'(2);
            dec_mid = dec_reg + dy_adv;
        end
        else
        begin
            y_adv  = step_y_reg;
            dy_adv = dy_reg;
            dec_mid = dec_reg;
        end
        x_adv  = step_x_reg + COORD_BITS'(1);
        dx_adv = dx_reg + DEC_BITS'(2);
    end

    always_comb
    begin
        ctr_x_next   = ctr_x_reg;
        ctr_y_next   = ctr_y_reg;
        color_next   = color_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        dec_next     = dec_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        running_next = running_reg;

        job.kind  = JOB_EMPTY;
        job.cx    = '0;
        job.cy    = '0;
        job.x     = '0;
        job.y     = '0;
        job.color = '0;
        job.done  = 1'b1;

        if (cmd == CMD_START)
        begin
            ctr_x_next = center_x;
            ctr_y_next = center_y;
            color_next = pen_color;
            if (radius != '0)
            begin
                dec_next     = DEC_BITS'(1) - DEC_BITS'(radius);
                dx_next      = DEC_BITS'(1);
                dy_next      = '0 - DEC_BITS'({radius, 1'b0});
                step_x_next  = '0;
                step_y_next  = radius_ext;
                running_next = 1'b1;
                job.kind  = JOB_AXES;
                job.cx    = center_x;
                job.cy    = center_y;
                job.y     = radius_ext;
                job.color = pen_color;
                job.done  = 1'b0;
            end
            else
            begin
                running_next = 1'b0;
            end
        end
        else if (running_reg)
        begin
            step_x_next  = x_adv;
            step_y_next  = y_adv;
            dy_next      = dy_adv;
            dx_next      = dx_adv;
            dec_next     = dec_mid + dx_adv;
            running_next = x_adv < y_adv;
            job.kind  = JOB_OCTANTS;
            job.cx    = ctr_x_reg;
            job.cy    = ctr_y_reg;
            job.x     = x_adv;
            job.y     = y_adv;
            job.color = color_reg;
            job.done  = !(x_adv < y_adv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x_reg   <= '0;
            ctr_y_reg   <= '0;
            color_reg   <= '0;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            dec_reg     <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            running_reg <= 1'b0;
        end
        else if (accept)
        begin
            ctr_x_reg   <= ctr_x_next;
            ctr_y_reg   <= ctr_y_next;
            color_reg   <= color_next;
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
            dec_reg     <= dec_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            running_reg <= running_next;
        end
    end

endmodule

// File: sv/mcog_queue.sv
// Job queue: small FIFO between the front end and the pixel back end.
`timescale 1ns / 1ps

module mcog_queue
    import mcog_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  job_t  push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output job_t  pop_data
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push_fire;
    logic                pop_fire;

    assign push_ready = count_reg != CNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("queue count did not follow a lone push");

endmodule

// File: sv/mcog_back.sv
// Back end: expands each job into mirrored pixels, clips them and holds the output register.
`timescale 1ns / 1ps

module mcog_back
    import mcog_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  job_t                   job,
    input  logic [SIZE_BITS-1:0]   scr_cols,
    input  logic [SIZE_BITS-1:0]   scr_rows,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_BITS-1:0]  pixel_x,
    output logic [COORD_BITS-1:0]  pixel_y,
    output logic [COLOR_BITS-1:0]  pixel_color,
    output logic                   visible,
    output logic                   last,
    output logic                   done_res
);

    logic [SEL_BITS-1:0]   step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic [COLOR_BITS-1:0] pixel_color_reg;
    logic                  visible_reg;
    logic                  last_reg;
    logic                  done_res_reg;

    logic                  fire;
    logic                  last_pix;
    logic [SEL_BITS-1:0]   sel;
    logic [SUM_BITS-1:0]   cx_w, cy_w, x_w, y_w;
    logic [SUM_BITS-1:0]   px, py;
    logic                  vis;

    // axis job uses octant slots 0, 2, 4 and 5: (0,+r) (0,-r) (+r,0) (-r,0)
    function automatic logic [SEL_BITS-1:0] axes_slot(input logic [SEL_BITS-1:0] idx);
        axes_slot = {idx[1], !idx[1] && idx[0], idx[1] && idx[0]};
    endfunction

    assign fire      = job_valid && (!out_valid_reg || out_ready);
    assign job_ready = fire && last_pix;

    always_comb
    begin
        case (job.kind)
            JOB_AXES:    last_pix = step_reg == AXES_LAST;
            JOB_OCTANTS: last_pix = step_reg == OCTANTS_LAST;
            default:     last_pix = 1'b1;
        endcase
    end

    assign sel  = (job.kind == JOB_AXES) ? axes_slot(step_reg) : step_reg;
    assign cx_w = SUM_BITS'(job.cx);
    assign cy_w = SUM_BITS'(job.cy);
    assign x_w  = SUM_BITS'(job.x);
    assign y_w  = SUM_BITS'(job.y);

    // slot bit 2 swaps x and y, bit 0 negates the column term, bit 1 the row term
    always_comb
    begin
        if (sel[2])
        begin
            px = sel[0] ? cx_w - y_w : cx_w + y_w;
            py = sel[1] ? cy_w - x_w : cy_w + x_w;
        end
        else
        begin
            px = sel[0] ? cx_w - x_w : cx_w + x_w;
            py = sel[1] ? cy_w - y_w : cy_w + y_w;
        end
    end

    assign vis = (job.kind != JOB_EMPTY)
              && !px[SUM_BITS-1] && !px[SUM_BITS-2]
              && !py[SUM_BITS-1] && !py[SUM_BITS-2]
              && (CMP_BITS'(px) < CMP_BITS'(scr_cols))
              && (CMP_BITS'(py) < CMP_BITS'(scr_rows));

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            step_next      = last_pix ? '0 : step_reg + SEL_BITS'(1);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pixel_x_reg     <= vis ? px[COORD_BITS-1:0] : '0;
            pixel_y_reg     <= vis ? py[COORD_BITS-1:0] : '0;
            pixel_color_reg <= job.color;
            visible_reg     <= vis;
            last_reg        <= last_pix;
            done_res_reg    <= job.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign visible     = visible_reg;
    assign last        = last_reg;
    assign done_res    = done_res_reg;

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0 |-> job_valid)
        else $error("job left the queue before its last pixel");

    a_clipped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !visible_reg) |-> (pixel_x_reg == '0 && pixel_y_reg == '0))
        else $error("clipped pixel carries coordinates");

endmodule

// File: sv/midpoint_circle_outline_generator.sv
// Top level: circle outline rasterizer with screen size registers.
`timescale 1ns / 1ps

// Midpoint circle outline generator. A start command (cmd = 0) latches the
// centre, radius and pen color and yields the four axis pixels; each step
// command (cmd = 1) runs one midpoint iteration and yields the eight mirrored
// pixels, with done_res set on all eight once the octant is finished. A zero
// radius start, or a step with no circle in progress, yields one empty result
// with last and done_res set. Pixels off screen come out with visible = 0 and
// zero coordinates. Pixels leave one per cycle from the output register while
// out_ready is high; that output stage is what sets the rate. The front end
// finishes its state update in the cycle a command is accepted and parks the
// pixel job in a two-entry queue, so it keeps accepting commands while earlier
// jobs drain. Screen width and height (register indexes 0 and 1) reset to 320
// and 240; the user must write them only while the block is idle, which the
// block itself does not enforce; the config port is always ready.
module midpoint_circle_outline_generator
    import mcog_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [COORD_BITS-1:0]      center_x,
    input  logic [COORD_BITS-1:0]      center_y,
    input  logic [RADIUS_BITS-1:0]     radius,
    input  logic [COLOR_BITS-1:0]      pen_color,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic [COLOR_BITS-1:0]      pixel_color,
    output logic                       visible,
    output logic                       last,
    output logic                       done_res,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [SIZE_BITS-1:0]       cfg_data
);

    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;

    // front -> queue
    logic job_in_valid;
    logic job_in_ready;
    job_t job_in;

    // queue -> back
    logic job_out_valid;
    logic job_out_ready;
    job_t job_out;

    assign cfg_ready = 1'b1;

    // screen size registers; a transfer on the config port lands here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_SCR_COLS: width_reg  <= cfg_data;
                CFG_SCR_ROWS: height_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // decision variables and command classification
    mcog_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .pen_color (pen_color),
        .job_valid (job_in_valid),
        .job       (job_in),
        .job_ready (job_in_ready)
    );

    // decouples command acceptance from pixel drain
    mcog_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_in_valid),
        .push_ready (job_in_ready),
        .push_data  (job_in),
        .pop_valid  (job_out_valid),
        .pop_ready  (job_out_ready),
        .pop_data   (job_out)
    );

    // mirrored pixel generation, clipping and output register
    mcog_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_out_valid),
        .job_ready   (job_out_ready),
        .job         (job_out),
        .scr_cols    (width_reg),
        .scr_rows    (height_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .visible     (visible),
        .last        (last),
        .done_res    (done_res)
    );

endmodule
